@@ hdl/dnsar_pkg.sv @@
package dnsar_pkg;

  localparam int unsigned PHASE_W = 4;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned LABEL_W = 6;

  localparam logic [PHASE_W-1:0] PH_HEADER = 4'd0;
  localparam logic [PHASE_W-1:0] PH_QNAME  = 4'd1;
  localparam logic [PHASE_W-1:0] PH_QLABEL = 4'd2;
  localparam logic [PHASE_W-1:0] PH_QPTR   = 4'd3;
  localparam logic [PHASE_W-1:0] PH_QFIXED = 4'd4;
  localparam logic [PHASE_W-1:0] PH_ANAME  = 4'd5;
  localparam logic [PHASE_W-1:0] PH_ALABEL = 4'd6;
  localparam logic [PHASE_W-1:0] PH_APTR   = 4'd7;
  localparam logic [PHASE_W-1:0] PH_AFIXED = 4'd8;
  localparam logic [PHASE_W-1:0] PH_RDSKIP = 4'd9;
  localparam logic [PHASE_W-1:0] PH_ADDR   = 4'd10;
  localparam logic [PHASE_W-1:0] PH_DONE   = 4'd11;

  localparam logic [15:0] TYPE_A   = 16'd1;
  localparam logic [15:0] CLASS_IN = 16'd1;
  localparam logic [15:0] A_RDLEN  = 16'd4;

  localparam int unsigned HDR_LAST_IDX   = 11;
  localparam int unsigned QFIX_LAST_IDX  = 3;
  localparam int unsigned AFIX_LAST_IDX  = 9;

  // Result word layout, lowest bit first.
  localparam int unsigned OK_LSB    = 0;
  localparam int unsigned ID_LSB    = 1;
  localparam int unsigned RCODE_LSB = 17;
  localparam int unsigned ANCNT_LSB = 21;
  localparam int unsigned HAS_A_LSB = 37;
  localparam int unsigned ADDR_LSB  = 38;
  localparam int unsigned TTL_LSB   = 70;
  localparam int unsigned RES_BITS  = 102;
  localparam int unsigned OUT_W     = 104;

  typedef struct packed {
    logic [31:0] ttl_seconds;
    logic [31:0] ipv4_addr;
    logic        a_found;
    logic [15:0] an_count;
    logic [3:0]  rcode;
    logic [15:0] message_id;
    logic        response_ok;
  } result_t;

endpackage

@@ hdl/dns_response_first_a_record_parser_top.sv @@
// DNS response parser: reports the header summary and the first IN A record.
// Input stream: one message byte per transaction on s_axis_tdata, with
// s_axis_tlast on the final byte of the message. Every byte updates a small
// set of field registers in the cycle it is taken.
// Output stream: one summary word per message, presented on m_axis_tdata the
// cycle after the final byte is taken.
// Throughput: one byte per cycle, unless the output register is full and stalled.
// The summary sits in an output register; s_axis_tready drops while that
// register is full and the receiver holds m_axis_tready low, so no summary is
// overwritten and input bytes wait until the summary is taken.
// After the final byte the parser returns to the header state at once, so
// the next message may follow in the next cycle if m_axis_tready is high.
// Reset (rst, synchronous) clears the parser and empties the output register.
module dns_response_first_a_record_parser_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // data_byte[7:0]
  input  logic                       s_axis_tlast,   // last_byte
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // response_ok[0], message_id[16:1], rcode[20:17], an_count[36:21],
  // a_found[37], ipv4_addr[69:38], ttl_seconds[101:70], zero pad[103:102]
  output logic [dnsar_pkg::OUT_W-1:0] m_axis_tdata
);
  import dnsar_pkg::*;

  logic [PHASE_W-1:0] phase, phase_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic [15:0]        hdr_id, hdr_id_next;
  logic [15:0]        hdr_flags, hdr_flags_next;
  logic [15:0]        q_left, q_left_next;
  logic [15:0]        a_left, a_left_next;
  logic [15:0]        a_total, a_total_next;
  logic [LABEL_W-1:0] label_left, label_left_next;
  logic [15:0]        rec_type, rec_type_next;
  logic [15:0]        rec_class, rec_class_next;
  logic [31:0]        rec_ttl, rec_ttl_next;
  logic [15:0]        rd_left, rd_left_next;
  logic [31:0]        addr, addr_next;
  logic               found, found_next;
  logic               stop, stop_next;

  logic    in_accept;
  logic    have_header, ok;
  result_t res;
  logic [7:0] b;

  assign b             = s_axis_tdata;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_comb begin
    phase_next      = phase;
    idx_next        = idx;
    hdr_id_next     = hdr_id;
    hdr_flags_next  = hdr_flags;
    q_left_next     = q_left;
    a_left_next     = a_left;
    a_total_next    = a_total;
    label_left_next = label_left;
    rec_type_next   = rec_type;
    rec_class_next  = rec_class;
    rec_ttl_next    = rec_ttl;
    rd_left_next    = rd_left;
    addr_next       = addr;
    found_next      = found;
    stop_next       = stop;
    if (!stop) begin
      unique case (phase) inside
        PH_HEADER: begin
          case (idx)
            4'd0: hdr_id_next[15:8]    = b;
            4'd1: hdr_id_next[7:0]     = b;
            4'd2: hdr_flags_next[15:8] = b;
            4'd3: hdr_flags_next[7:0]  = b;
            4'd4: q_left_next[15:8]    = b;
            4'd5: q_left_next[7:0]     = b;
            4'd6: a_total_next[15:8]   = b;
            4'd7: begin
              a_total_next[7:0] = b;
              a_left_next       = {a_total[15:8], b};
            end
            default: ;
          endcase
          if (idx >= IDX_W'(HDR_LAST_IDX)) begin
            idx_next = '0;
            if (!hdr_flags_next[15] || hdr_flags_next[3:0] != 4'd0 ||
                q_left_next == 16'd0 || a_total_next == 16'd0) begin
              phase_next = PH_DONE;
              stop_next  = 1'b1;
            end else begin
              phase_next = PH_QNAME;
            end
          end else begin
            idx_next = idx + 1'b1;
          end
        end
        PH_QNAME, PH_ANAME: begin
          if (b == 8'd0) begin
            phase_next = (phase == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
            idx_next   = '0;
          end else if (b[7:6] == 2'b11) begin
            phase_next = (phase == PH_QNAME) ? PH_QPTR : PH_APTR;
          end else if (b[7:6] != 2'b00) begin
            phase_next = PH_DONE;
            stop_next  = 1'b1;
          end else begin
            label_left_next = b[5:0];
            phase_next      = (phase == PH_QNAME) ? PH_QLABEL : PH_ALABEL;
          end
        end
        PH_QLABEL, PH_ALABEL: begin
          label_left_next = label_left - 1'b1;
          if (label_left_next == '0)
            phase_next = (phase == PH_QLABEL) ? PH_QNAME : PH_ANAME;
        end
        PH_QPTR: begin
          phase_next = PH_QFIXED;
          idx_next   = '0;
        end
        PH_APTR: begin
          phase_next = PH_AFIXED;
          idx_next   = '0;
        end
        PH_QFIXED: begin
          if (idx >= IDX_W'(QFIX_LAST_IDX)) begin
            idx_next    = '0;
            q_left_next = q_left - 1'b1;
            phase_next  = (q_left_next == 16'd0) ? PH_ANAME : PH_QNAME;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
        PH_AFIXED: begin
          case (idx)
            4'd0:    rec_type_next[15:8]  = b;
            4'd1:    rec_type_next[7:0]   = b;
            4'd2:    rec_class_next[15:8] = b;
            4'd3:    rec_class_next[7:0]  = b;
            4'd4:    rec_ttl_next         = {b, 24'd0};
            4'd5:    rec_ttl_next[23:16]  = b;
            4'd6:    rec_ttl_next[15:8]   = b;
            4'd7:    rec_ttl_next[7:0]    = b;
            4'd8:    rd_left_next         = {b, 8'd0};
            default: rd_left_next[7:0]    = rd_left[7:0] | b;
          endcase
          if (idx >= IDX_W'(AFIX_LAST_IDX)) begin
            idx_next = '0;
            if (rec_type == TYPE_A && rec_class == CLASS_IN && rd_left_next == A_RDLEN) begin
              addr_next  = '0;
              phase_next = PH_ADDR;
            end else if (rd_left_next == 16'd0) begin
              a_left_next = a_left - 1'b1;
              if (a_left_next == 16'd0) begin
                phase_next = PH_DONE;
                stop_next  = 1'b1;
              end else begin
                phase_next = PH_ANAME;
              end
            end else begin
              phase_next = PH_RDSKIP;
            end
          end else begin
            idx_next = idx + 1'b1;
          end
        end
        PH_RDSKIP: begin
          rd_left_next = rd_left - 1'b1;
          if (rd_left_next == 16'd0) begin
            a_left_next = a_left - 1'b1;
            if (a_left_next == 16'd0) begin
              phase_next = PH_DONE;
              stop_next  = 1'b1;
            end else begin
              phase_next = PH_ANAME;
            end
          end
        end
        PH_ADDR: begin
          addr_next    = {addr[23:0], b};
          rd_left_next = rd_left - 1'b1;
          if (rd_left_next == 16'd0) begin
            found_next = 1'b1;
            phase_next = PH_DONE;
            stop_next  = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Summary is built from the state after the final byte has been applied.
  always_comb begin
    have_header      = phase_next != PH_HEADER;
    ok               = have_header && hdr_flags_next[15];
    res.response_ok  = ok;
    res.message_id   = have_header ? hdr_id_next : 16'd0;
    res.rcode        = ok ? hdr_flags_next[3:0] : 4'd0;
    res.an_count     = ok ? a_total_next : 16'd0;
    res.a_found      = found_next;
    res.ipv4_addr    = found_next ? addr_next : 32'd0;
    res.ttl_seconds  = found_next ? rec_ttl_next : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (in_accept && s_axis_tlast)) begin
      phase      <= PH_HEADER;
      idx        <= '0;
      hdr_id     <= '0;
      hdr_flags  <= '0;
      q_left     <= '0;
      a_left     <= '0;
      a_total    <= '0;
      label_left <= '0;
      rec_type   <= '0;
      rec_class  <= '0;
      rec_ttl    <= '0;
      rd_left    <= '0;
      addr       <= '0;
      found      <= 1'b0;
      stop       <= 1'b0;
    end else if (in_accept) begin
      phase      <= phase_next;
      idx        <= idx_next;
      hdr_id     <= hdr_id_next;
      hdr_flags  <= hdr_flags_next;
      q_left     <= q_left_next;
      a_left     <= a_left_next;
      a_total    <= a_total_next;
      label_left <= label_left_next;
      rec_type   <= rec_type_next;
      rec_class  <= rec_class_next;
      rec_ttl    <= rec_ttl_next;
      rd_left    <= rd_left_next;
      addr       <= addr_next;
      found      <= found_next;
      stop       <= stop_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_accept && s_axis_tlast) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && s_axis_tlast) begin
      m_axis_tdata <= {(OUT_W - RES_BITS)'(0), res};
    end
  end

endmodule

@@ hdl/dnsar_checker.sv @@
module dnsar_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        s_axis_tlast,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [dnsar_pkg::OUT_W-1:0] m_axis_tdata
);
  import dnsar_pkg::*;

  // A stalled summary holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("summary changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // A new summary appears only after a final-byte transaction.
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
    else $error("summary without final byte");

  a_no_record_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[HAS_A_LSB] |->
      m_axis_tdata[ADDR_LSB +: 32] == 32'd0 && m_axis_tdata[TTL_LSB +: 32] == 32'd0)
    else $error("address or ttl without record");

  a_not_ok_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[OK_LSB] |->
      m_axis_tdata[RCODE_LSB +: 4] == 4'd0 && m_axis_tdata[ANCNT_LSB +: 16] == 16'd0)
    else $error("rcode or answer count on non-response");

endmodule

bind dns_response_first_a_record_parser_top dnsar_checker u_dnsar_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ bench/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dnsar_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 100000;
  localparam int unsigned RANDOM_BYTES = 1550;
  localparam int unsigned QUIET_AFTER  = 1300;
  localparam int unsigned LONG_HOLD    = 60;
  localparam int unsigned PRESSURE_MSG = 6;

  localparam logic [15:0] TYPE_CNAME = 16'd5;
  localparam logic [15:0] TYPE_AAAA  = 16'd28;
  localparam logic [15:0] CLASS_CH   = 16'd3;
  localparam logic [7:0]  PTR_TAG    = 8'hC0;
  localparam logic [7:0]  NAME_END   = 8'h00;
  localparam int unsigned LABEL_MAX  = 63;

  // id FFFF, QR set with rcode 15, no questions, ANCOUNT FFFF
  localparam logic [7:0] HDR_MAX [12] = '{8'hFF, 8'hFF, 8'h8F, 8'h0F, 8'h00, 8'h00,
                                          8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
  // one byte short of a full header
  localparam logic [7:0] HDR_SHORT [11] = '{8'h12, 8'h34, 8'h80, 8'h00, 8'h00, 8'h01,
                                            8'h00, 8'h01, 8'h00, 8'h00, 8'h00};

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         typed;
    result_t    want;
  } stim_row_t;

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;
  logic                 s_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OUT_W-1:0]     m_axis_tdata;

  // parser model state
  logic [PHASE_W-1:0]   phase;
  logic [IDX_W-1:0]     idx;
  logic [15:0]          hdr_id;
  logic [15:0]          hdr_flags;
  logic [15:0]          qd_left;
  logic [15:0]          an_left;
  logic [15:0]          an_total;
  logic [LABEL_W-1:0]   lbl_left;
  logic [15:0]          rr_type;
  logic [15:0]          rr_class;
  logic [31:0]          rr_ttl;
  logic [15:0]          rd_left;
  logic [31:0]          addr_acc;
  bit                   got_a;
  bit                   halted;

  result_t              summaries_due[$];
  stim_row_t            stim_tab[$];
  logic [7:0]           msg[$];
  int                   mismatches = 0;
  int                   sent_bytes = 0;
  bit                   quiet_tail;
  bit                   hold_req;

  dns_response_first_a_record_parser_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic void clear_parser();
    phase    = PH_HEADER;
    idx      = '0;
    hdr_id   = '0;
    hdr_flags = '0;
    qd_left  = '0;
    an_left  = '0;
    an_total = '0;
    lbl_left = '0;
    rr_type  = '0;
    rr_class = '0;
    rr_ttl   = '0;
    rd_left  = '0;
    addr_acc = '0;
    got_a    = 1'b0;
    halted   = 1'b0;
  endfunction

  function automatic void stop_parse();
    phase  = PH_DONE;
    halted = 1'b1;
  endfunction

  function automatic void next_answer();
    an_left = an_left - 16'd1;
    if (an_left == '0) stop_parse();
    else phase = PH_ANAME;
  endfunction

  function automatic void name_byte(input logic [7:0] b, input logic [PHASE_W-1:0] lbl_ph,
                                    input logic [PHASE_W-1:0] ptr_ph,
                                    input logic [PHASE_W-1:0] fix_ph);
    if (b == NAME_END) begin
      phase = fix_ph;
      idx   = '0;
    end else if ((b & PTR_TAG) == PTR_TAG) begin
      phase = ptr_ph;
    end else if ((b & PTR_TAG) != 8'h00) begin
      // label types 01 and 10 are reserved
      stop_parse();
    end else begin
      lbl_left = b[LABEL_W-1:0];
      phase    = lbl_ph;
    end
  endfunction

  function automatic void consume_byte(input logic [7:0] b);
    case (phase)
      PH_HEADER: begin
        case (idx)
          4'd0: hdr_id = {b, 8'h00};
          4'd1: hdr_id = hdr_id | 16'(b);
          4'd2: hdr_flags = {b, 8'h00};
          4'd3: hdr_flags = hdr_flags | 16'(b);
          4'd4: qd_left = {b, 8'h00};
          4'd5: qd_left = qd_left | 16'(b);
          4'd6: an_total = {b, 8'h00};
          4'd7: begin
            an_total = an_total | 16'(b);
            an_left  = an_total;
          end
          default: ;
        endcase
        if (idx >= HDR_LAST_IDX) begin
          idx = '0;
          if (!hdr_flags[15] || hdr_flags[3:0] != 4'd0 || qd_left == '0 || an_total == '0)
            stop_parse();
          else
            phase = PH_QNAME;
        end else begin
          idx = idx + 1'b1;
        end
      end
      PH_QNAME: name_byte(b, PH_QLABEL, PH_QPTR, PH_QFIXED);
      PH_ANAME: name_byte(b, PH_ALABEL, PH_APTR, PH_AFIXED);
      PH_QLABEL, PH_ALABEL: begin
        lbl_left = lbl_left - 1'b1;
        if (lbl_left == '0) phase = (phase == PH_QLABEL) ? PH_QNAME : PH_ANAME;
      end
      PH_QPTR: begin
        phase = PH_QFIXED;
        idx   = '0;
      end
      PH_APTR: begin
        phase = PH_AFIXED;
        idx   = '0;
      end
      PH_QFIXED: begin
        if (idx >= QFIX_LAST_IDX) begin
          idx     = '0;
          qd_left = qd_left - 16'd1;
          phase   = (qd_left == '0) ? PH_ANAME : PH_QNAME;
        end else begin
          idx = idx + 1'b1;
        end
      end
      PH_AFIXED: begin
        case (idx)
          4'd0: rr_type = {b, 8'h00};
          4'd1: rr_type = rr_type | 16'(b);
          4'd2: rr_class = {b, 8'h00};
          4'd3: rr_class = rr_class | 16'(b);
          4'd4: rr_ttl = {b, 24'h0};
          4'd5: rr_ttl = rr_ttl | {8'h00, b, 16'h0};
          4'd6: rr_ttl = rr_ttl | {16'h0, b, 8'h00};
          4'd7: rr_ttl = rr_ttl | 32'(b);
          4'd8: rd_left = {b, 8'h00};
          default: rd_left = rd_left | 16'(b);
        endcase
        if (idx >= AFIX_LAST_IDX) begin
          idx = '0;
          if (rr_type == TYPE_A && rr_class == CLASS_IN && rd_left == A_RDLEN) begin
            addr_acc = '0;
            phase    = PH_ADDR;
          end else if (rd_left == '0) begin
            next_answer();
          end else begin
            phase = PH_RDSKIP;
          end
        end else begin
          idx = idx + 1'b1;
        end
      end
      PH_RDSKIP: begin
        rd_left = rd_left - 16'd1;
        if (rd_left == '0) next_answer();
      end
      PH_ADDR: begin
        addr_acc = {addr_acc[23:0], b};
        rd_left  = rd_left - 16'd1;
        if (rd_left == '0) begin
          got_a = 1'b1;
          stop_parse();
        end
      end
      default: ;
    endcase
  endfunction

  // returns 1 when the byte closes a message; sum then holds its summary
  function automatic bit parse_byte(input logic [7:0] b, input logic lst, output result_t sum);
    bit have_hdr;
    bit ok;
    sum = '0;
    if (!halted) consume_byte(b);
    if (!lst) return 1'b0;
    have_hdr         = (phase != PH_HEADER);
    ok               = have_hdr && hdr_flags[15];
    sum.response_ok  = ok;
    sum.message_id   = have_hdr ? hdr_id : 16'h0;
    sum.rcode        = ok ? hdr_flags[3:0] : 4'h0;
    sum.an_count     = ok ? an_total : 16'h0;
    sum.a_found      = got_a;
    sum.ipv4_addr    = got_a ? addr_acc : 32'h0;
    sum.ttl_seconds  = got_a ? rr_ttl : 32'h0;
    clear_parser();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[RES_BITS-1:0];
      if (summaries_due.size() == 0) begin
        $error("summary with none pending: %h", got);
        mismatches++;
      end else begin
        want = summaries_due.pop_front();
        check_field("response_ok", 32'(want.response_ok), 32'(got.response_ok));
        check_field("message_id", 32'(want.message_id), 32'(got.message_id));
        check_field("rcode", 32'(want.rcode), 32'(got.rcode));
        check_field("an_count", 32'(want.an_count), 32'(got.an_count));
        check_field("a_found", 32'(want.a_found), 32'(got.a_found));
        check_field("ipv4_addr", want.ipv4_addr, got.ipv4_addr);
        check_field("ttl_seconds", want.ttl_seconds, got.ttl_seconds);
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- sender

  task automatic send_byte(input logic [7:0] b, input logic lst, input bit typed,
                           input result_t want);
    result_t sum;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= lst;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (parse_byte(b, lst, sum)) summaries_due.push_back(typed ? want : sum);
    @(negedge clk);
  endtask

  task automatic send_msg();
    foreach (msg[i]) begin
      send_byte(msg[i], i == msg.size() - 1, 1'b0, '0);
      sent_bytes++;
      if (sent_bytes >= QUIET_AFTER) quiet_tail = 1'b1;
    end
  endtask

  task automatic add_row(input logic [7:0] b, input logic lst, input bit typed,
                         input result_t want);
    stim_row_t row;
    row.data  = b;
    row.last  = lst;
    row.typed = typed;
    row.want  = want;
    stim_tab.push_back(row);
  endtask

  task automatic push16(input logic [15:0] v);
    msg.push_back(v[15:8]);
    msg.push_back(v[7:0]);
  endtask

  task automatic push_name();
    int pick;
    int len;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      msg.push_back(PTR_TAG | 8'($urandom_range(0, 63)));
      msg.push_back(8'($urandom));
    end else if (pick == 2) begin
      msg.push_back(NAME_END);
    end else begin
      repeat ($urandom_range(1, 3)) begin
        len = ($urandom_range(0, 15) == 0) ? LABEL_MAX : $urandom_range(1, 8);
        msg.push_back(8'(len));
        repeat (len) msg.push_back(8'($urandom));
      end
      // names may also end in a compression pointer after some labels
      if ($urandom_range(0, 3) == 0) begin
        msg.push_back(PTR_TAG | 8'($urandom_range(0, 63)));
        msg.push_back(8'($urandom));
      end else begin
        msg.push_back(NAME_END);
      end
    end
  endtask

  task automatic build_noise(input int max_len);
    msg.delete();
    repeat ($urandom_range(1, max_len)) msg.push_back(8'($urandom));
  endtask

  task automatic build_response();
    logic [15:0] flg;
    logic [15:0] qd;
    logic [15:0] an;
    logic [15:0] rtype;
    logic [15:0] rclass;
    logic [15:0] rdlen;
    logic [31:0] ttl;
    int          pick;
    int          nq;
    int          na;
    bit          cut;
    msg.delete();
    flg  = (16'($urandom) & 16'h7FF0) | 16'h8000;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      flg[15]  = 1'b0;
      flg[3:0] = 4'($urandom);
    end else if (pick == 1) begin
      flg[3:0] = 4'($urandom_range(1, 15));
    end
    pick = $urandom_range(0, 11);
    qd = (pick == 0) ? 16'd0 : (pick == 1) ? 16'($urandom) : (pick < 4) ? 16'd2 : 16'd1;
    pick = $urandom_range(0, 11);
    an = (pick == 0) ? 16'd0 : (pick == 1) ? 16'($urandom) : 16'($urandom_range(1, 3));
    push16(16'($urandom));
    push16(flg);
    push16(qd);
    push16(an);
    push16(16'($urandom));
    push16(16'($urandom));
    nq = (qd > 16'd3) ? 3 : int'(qd);
    repeat (nq) begin
      push_name();
      repeat (4) msg.push_back(8'($urandom));
    end
    na  = (an > 16'd3) ? 3 : int'(an);
    cut = 1'b0;
    for (int i = 0; i < na && !cut; i++) begin
      push_name();
      ttl    = $urandom;
      rtype  = TYPE_A;
      rclass = CLASS_IN;
      rdlen  = A_RDLEN;
      case ($urandom_range(0, 9))
        5: begin
          rtype = TYPE_AAAA;
          rdlen = 16'd16;
        end
        6: begin
          rtype = TYPE_CNAME;
          rdlen = 16'($urandom_range(0, 20));
        end
        7: rclass = CLASS_CH;
        8: rdlen = 16'($urandom_range(0, 8));
        9: begin
          // arbitrary record; message is cut inside its data
          rtype  = 16'($urandom);
          rclass = 16'($urandom);
          rdlen  = 16'($urandom);
          cut    = 1'b1;
        end
        default: ;
      endcase
      push16(rtype);
      push16(rclass);
      push16(ttl[31:16]);
      push16(ttl[15:0]);
      push16(rdlen);
      repeat (cut ? $urandom_range(0, 24) : int'(rdlen)) msg.push_back(8'($urandom));
    end
    if (!cut) repeat ($urandom_range(0, 3)) msg.push_back(8'($urandom));
    if (msg.size() > 12 && $urandom_range(0, 9) == 0)
      msg[$urandom_range(12, msg.size() - 1)] = 8'($urandom_range(64, 191));
    if ($urandom_range(0, 7) == 0) begin
      pick = $urandom_range(1, msg.size());
      while (msg.size() > pick) void'(msg.pop_back());
    end
  endtask

  task automatic wait_drained();
    while (summaries_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    result_t want;
    int      msg_count;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    quiet_tail    = 1'b0;
    hold_req      = 1'b0;
    clear_parser();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single-byte message: no header, all fields zero
    add_row(8'hFF, 1'b1, 1'b1, '0);
    want              = '0;
    want.response_ok  = 1'b1;
    want.message_id   = 16'hFFFF;
    want.rcode        = 4'hF;
    want.an_count     = 16'hFFFF;
    foreach (HDR_MAX[i]) add_row(HDR_MAX[i], i == 11, i == 11, want);
    foreach (HDR_SHORT[i]) add_row(HDR_SHORT[i], i == 10, i == 10, '0);

    foreach (stim_tab[i]) send_byte(stim_tab[i].data, stim_tab[i].last, stim_tab[i].typed,
                                    stim_tab[i].want);

    msg_count  = 0;
    sent_bytes = 0;
    while (sent_bytes < RANDOM_BYTES) begin
      if ($urandom_range(0, 3) == 0) build_noise(20);
      else build_response();
      send_msg();
      msg_count++;
      if (msg_count == PRESSURE_MSG) begin
        // receiver stalls long while short messages keep coming
        hold_req = 1'b1;
        repeat (6) begin
          build_noise(3);
          send_msg();
        end
        s_axis_tvalid <= 1'b0;
        wait_drained();
      end
    end
    s_axis_tvalid <= 1'b0;

    while (summaries_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
